/* rtl/cts_pkg.sv */
// Shared types, pattern tables and result codes for the content type sniffer.
`default_nettype none

package cts_pkg;

    // Number of HTML openings and binary signatures
    localparam int HTML_COUNT = 5;
    localparam int SIG_COUNT  = 4;

    // Longest HTML opening; the tag offset saturates here
    localparam logic [4:0] TAG_MAX = 5'd17;

    // Pattern text, index 0 is the first byte; unused tail bytes are zero
    typedef logic [0:16][7:0] html_text_t;
    typedef logic [0:3][7:0]  sig_text_t;

    localparam html_text_t HTML_TEXT [HTML_COUNT] = '{
        {"<html", 96'h0},
        {"<head", 96'h0},
        {"<title", 88'h0},
        {"<!doctype html", 24'h0},
        {"<!-- html listing"}
    };

    localparam logic [4:0] HTML_LEN [HTML_COUNT] = '{
        5'd5, 5'd5, 5'd6, 5'd14, 5'd17
    };

    localparam sig_text_t SIG_TEXT [SIG_COUNT] = '{
        {"gif8"},
        {8'h89, "png"},
        {8'hFF, 8'hD8, 16'h0},
        {"bm", 16'h0}
    };

    localparam logic [2:0] SIG_LEN [SIG_COUNT] = '{
        3'd4, 3'd4, 3'd2, 3'd2
    };

    // Result codes
    typedef enum logic [2:0] {
        TYPE_BINARY = 3'd0,
        TYPE_HTML   = 3'd1,
        TYPE_TEXT   = 3'd2,
        TYPE_GIF    = 3'd3,
        TYPE_PNG    = 3'd4,
        TYPE_JPEG   = 3'd5,
        TYPE_BMP    = 3'd6
    } type_code_t;

    localparam type_code_t SIG_CODE [SIG_COUNT] = '{
        TYPE_GIF, TYPE_PNG, TYPE_JPEG, TYPE_BMP
    };

    // Per-pattern mismatch flags for one byte
    typedef struct packed {
        logic [HTML_COUNT-1:0] html;
        logic [SIG_COUNT-1:0]  sig;
    } match_t;

endpackage

`default_nettype wire

/* rtl/cts_match.sv */
// Byte comparator: flags which HTML openings and signatures a byte breaks.
`default_nettype none

module cts_match (
    input  logic [7:0]      data_byte,
    input  logic [4:0]      tag_offset,
    input  logic [2:0]      lead_offset,
    output cts_pkg::match_t miss
);
    import cts_pkg::*;

    logic [7:0] folded;

    // ASCII upper case folds to lower case
    always_comb
    begin
        if (data_byte >= 8'h41 && data_byte <= 8'h5A)
            folded = data_byte + 8'd32;
        else
            folded = data_byte;
    end

    // Compare against every pattern at its current position
    always_comb
    begin
        miss = '0;
        for (int k = 0; k < HTML_COUNT; k++)
        begin
            if (tag_offset < HTML_LEN[k] && folded != HTML_TEXT[k][tag_offset])
                miss.html[k] = 1'b1;
        end
        for (int k = 0; k < SIG_COUNT; k++)
        begin
            if (lead_offset < SIG_LEN[k] && folded != SIG_TEXT[k][lead_offset[1:0]])
                miss.sig[k] = 1'b1;
        end
    end

endmodule

`default_nettype wire

/* rtl/content_type_sniffer_unit.sv */
// Content type sniffer top level: input register, match logic, result register.
// A resource's result is registered once its ending word leaves the input register.
// Throughput: one byte word per cycle; the input register and the result register
// are the only stages, so a new word is taken every cycle unless the result is held.
// Reset: rst_n clears all match state and both valid flags asynchronously.
`default_nettype none

module content_type_sniffer_unit #(
    parameter int ASCII_WINDOW = 256
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    input  logic       is_empty,
    input  logic       url_is_text,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [2:0] type_code,
    output logic       use_url_type
);
    import cts_pkg::*;

    localparam int SEEN_CAP = ASCII_WINDOW + 4;
    localparam int SEEN_W   = $clog2(SEEN_CAP + 1);

    // Input register
    logic       s1_valid_reg, s1_valid_next;
    logic [7:0] s1_data_reg;
    logic       s1_last_reg;
    logic       s1_empty_reg;
    logic       s1_url_reg;

    // Resource state
    logic                  past_space_reg, past_space_next;
    logic [4:0]            tag_offset_reg, tag_offset_next;
    logic [HTML_COUNT-1:0] html_alive_reg, html_alive_next;
    logic [SIG_COUNT-1:0]  sig_alive_reg, sig_alive_next;
    logic [SEEN_W-1:0]     bytes_seen_reg, bytes_seen_next;
    logic                  non_ascii_reg, non_ascii_next;

    // Result register
    logic       out_valid_reg, out_valid_next;
    type_code_t type_code_reg, type_code_next;
    logic       use_url_reg, use_url_next;

    // Handshake
    logic in_take;
    logic out_free;
    logic s1_ends;
    logic s1_go;
    logic s1_fire;

    // Byte update path
    logic                  is_space;
    logic                  past_upd;
    logic [4:0]            tag_upd;
    logic [HTML_COUNT-1:0] html_upd;
    logic [SIG_COUNT-1:0]  sig_upd;
    logic [SEEN_W-1:0]     seen_upd;
    logic                  non_ascii_upd;
    logic [2:0]            lead_offset;
    match_t                miss;
    logic                  html_hit;
    type_code_t            code;

    // Pipeline control: a word that ends a resource needs room in the result register
    always_comb
    begin
        out_free  = !out_valid_reg || !out_stall;
        s1_ends   = s1_empty_reg || s1_last_reg;
        s1_go     = !s1_ends || out_free;
        s1_fire   = s1_valid_reg && s1_go;
        in_stall  = s1_valid_reg && !s1_go;
        in_take   = in_valid && !in_stall;
        s1_valid_next  = in_take || (s1_valid_reg && !s1_go);
        out_valid_next = (s1_fire && s1_ends) || (out_valid_reg && out_stall);
    end

    // Position of the byte among the first few of the resource
    always_comb
    begin
        if (bytes_seen_reg >= SEEN_W'(4))
            lead_offset = 3'd4;
        else
            lead_offset = bytes_seen_reg[2:0];
    end

    cts_match u_match (
        .data_byte   (s1_data_reg),
        .tag_offset  (tag_offset_reg),
        .lead_offset (lead_offset),
        .miss        (miss)
    );

    // State after taking the byte in the input register (no change for an empty mark)
    always_comb
    begin
        is_space = (s1_data_reg == 8'h20) ||
                   (s1_data_reg >= 8'h09 && s1_data_reg <= 8'h0D);
        past_upd      = past_space_reg;
        tag_upd       = tag_offset_reg;
        html_upd      = html_alive_reg;
        sig_upd       = sig_alive_reg;
        seen_upd      = bytes_seen_reg;
        non_ascii_upd = non_ascii_reg;
        if (!s1_empty_reg)
        begin
            sig_upd = sig_alive_reg & ~miss.sig;
            if (bytes_seen_reg < SEEN_W'(ASCII_WINDOW) && s1_data_reg[7])
                non_ascii_upd = 1'b1;
            if (past_space_reg || !is_space)
            begin
                past_upd = 1'b1;
                html_upd = html_alive_reg & ~miss.html;
                if (tag_offset_reg < TAG_MAX)
                    tag_upd = tag_offset_reg + 5'd1;
            end
            if (bytes_seen_reg < SEEN_W'(SEEN_CAP))
                seen_upd = bytes_seen_reg + SEEN_W'(1);
        end
    end

    // Classification by priority: HTML, signatures in order, then text or binary
    always_comb
    begin
        html_hit = 1'b0;
        for (int k = 0; k < HTML_COUNT; k++)
        begin
            if (html_upd[k] && tag_upd >= HTML_LEN[k])
                html_hit = 1'b1;
        end
        code = non_ascii_upd ? TYPE_BINARY : TYPE_TEXT;
        for (int k = SIG_COUNT - 1; k >= 0; k--)
        begin
            if (sig_upd[k] && seen_upd >= SEEN_W'(SIG_LEN[k]))
                code = SIG_CODE[k];
        end
        if (html_hit)
            code = TYPE_HTML;
        type_code_next = code;
        use_url_next   = (code == TYPE_TEXT) && s1_url_reg;
    end

    // Next resource state: clear after the ending word
    always_comb
    begin
        past_space_next = past_space_reg;
        tag_offset_next = tag_offset_reg;
        html_alive_next = html_alive_reg;
        sig_alive_next  = sig_alive_reg;
        bytes_seen_next = bytes_seen_reg;
        non_ascii_next  = non_ascii_reg;
        if (s1_fire)
        begin
            if (s1_ends)
            begin
                past_space_next = 1'b0;
                tag_offset_next = '0;
                html_alive_next = '1;
                sig_alive_next  = '1;
                bytes_seen_next = '0;
                non_ascii_next  = 1'b0;
            end
            else
            begin
                past_space_next = past_upd;
                tag_offset_next = tag_upd;
                html_alive_next = html_upd;
                sig_alive_next  = sig_upd;
                bytes_seen_next = seen_upd;
                non_ascii_next  = non_ascii_upd;
            end
        end
    end

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            past_space_reg <= 1'b0;
            tag_offset_reg <= '0;
            html_alive_reg <= '1;
            sig_alive_reg  <= '1;
            bytes_seen_reg <= '0;
            non_ascii_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg   <= s1_valid_next;
            out_valid_reg  <= out_valid_next;
            past_space_reg <= past_space_next;
            tag_offset_reg <= tag_offset_next;
            html_alive_reg <= html_alive_next;
            sig_alive_reg  <= sig_alive_next;
            bytes_seen_reg <= bytes_seen_next;
            non_ascii_reg  <= non_ascii_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_data_reg  <= data_byte;
            s1_last_reg  <= last_byte;
            s1_empty_reg <= is_empty;
            s1_url_reg   <= url_is_text;
        end
        if (s1_fire && s1_ends)
        begin
            type_code_reg <= type_code_next;
            use_url_reg   <= use_url_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign type_code    = type_code_reg;
    assign use_url_type = use_url_reg;

endmodule

`default_nettype wire

/* tb/content_type_sniffer_unit_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the content type sniffer: directed and random resources.
module content_type_sniffer_unit_tb;
    import cts_pkg::*;

    localparam int WINDOW       = 256;
    localparam int SEEN_LIMIT   = WINDOW + 4;
    localparam int TAG_LIMIT    = 17;
    localparam int RANDOM_WORDS = 760;
    localparam int BURST_WORDS  = 300;

    typedef struct packed {
        type_code_t code;
        logic       use_url;
    } sniff_result_t;

    logic       clk         = 1'b0;
    logic       rst_n       = 1'b0;
    logic       in_valid    = 1'b0;
    logic       in_stall;
    logic [7:0] data_byte   = 8'h00;
    logic       last_byte   = 1'b0;
    logic       is_empty    = 1'b0;
    logic       url_is_text = 1'b0;
    logic       out_valid;
    logic       out_stall   = 1'b0;
    logic [2:0] type_code;
    logic       use_url_type;

    // Predictor state for the resource in flight
    logic       lead_done;
    logic [4:0] tag_pos;
    logic [4:0] html_live;
    logic [3:0] sig_live;
    logic [8:0] byte_count;
    logic       high_seen;

    sniff_result_t expected_types[$];
    logic [7:0]    resource_bytes[$];
    bit            jitter_on = 1'b1;
    int            words_sent = 0;
    int            mismatch_count = 0;

    content_type_sniffer_unit uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .data_byte    (data_byte),
        .last_byte    (last_byte),
        .is_empty     (is_empty),
        .url_is_text  (url_is_text),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .type_code    (type_code),
        .use_url_type (use_url_type)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Pattern tables, lowercase; a byte is folded before comparing
    function automatic int html_len(input int k);
        case (k)
            0, 1:    return 5;
            2:       return 6;
            3:       return 14;
            default: return 17;
        endcase
    endfunction

    function automatic logic [7:0] html_char(input int k, input int i);
        string s;
        case (k)
            0:       s = "<html";
            1:       s = "<head";
            2:       s = "<title";
            3:       s = "<!doctype html";
            default: s = "<!-- html listing";
        endcase
        return (i < s.len()) ? s[i] : 8'h00;
    endfunction

    function automatic int sig_len(input int k);
        return (k < 2) ? 4 : 2;
    endfunction

    function automatic logic [7:0] sig_char(input int k, input int i);
        logic [31:0] pat;
        case (k)
            0:       pat = 32'h6769_6638;
            1:       pat = 32'h8970_6E67;
            2:       pat = 32'hFFD8_0000;
            default: pat = 32'h626D_0000;
        endcase
        return pat[31 - 8 * i -: 8];
    endfunction

    function automatic type_code_t sig_type(input int k);
        case (k)
            0:       return TYPE_GIF;
            1:       return TYPE_PNG;
            2:       return TYPE_JPEG;
            default: return TYPE_BMP;
        endcase
    endfunction

    function automatic logic is_ws(input logic [7:0] b);
        return (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
    endfunction

    task automatic clear_sniff_state();
        lead_done  = 1'b0;
        tag_pos    = '0;
        html_live  = '1;
        sig_live   = '1;
        byte_count = '0;
        high_seen  = 1'b0;
    endtask

    // Update the match flags with one resource byte
    task automatic absorb_sniff_byte(input logic [7:0] b);
        logic [7:0] lb;
        int         k;
        lb = (b >= 8'h41 && b <= 8'h5A) ? b + 8'd32 : b;
        for (k = 0; k < 4; k++)
            if (byte_count < sig_len(k) && lb != sig_char(k, byte_count))
                sig_live[k] = 1'b0;
        if (byte_count < WINDOW && b[7])
            high_seen = 1'b1;
        if (lead_done || !is_ws(b))
        begin
            lead_done = 1'b1;
            for (k = 0; k < 5; k++)
                if (tag_pos < html_len(k) && lb != html_char(k, tag_pos))
                    html_live[k] = 1'b0;
            if (tag_pos < TAG_LIMIT)
                tag_pos = tag_pos + 5'd1;
        end
        if (byte_count < SEEN_LIMIT)
            byte_count = byte_count + 9'd1;
    endtask

    function automatic type_code_t classify_resource();
        int k;
        for (k = 0; k < 5; k++)
            if (html_live[k] && tag_pos >= html_len(k))
                return TYPE_HTML;
        for (k = 0; k < 4; k++)
            if (sig_live[k] && byte_count >= sig_len(k))
                return sig_type(k);
        return high_seen ? TYPE_BINARY : TYPE_TEXT;
    endfunction

    // Predict the effect of one accepted word
    task automatic track_word(input logic [7:0] b, input logic last, input logic empty,
                              input logic url);
        sniff_result_t r;
        if (!empty)
            absorb_sniff_byte(b);
        if (empty || last)
        begin
            r.code    = classify_resource();
            r.use_url = (r.code == TYPE_TEXT) && url;
            expected_types.push_back(r);
            clear_sniff_state();
        end
    endtask

    // Offer one word, with random gaps, and hold it until accepted
    task automatic send_word(input logic [7:0] b, input logic last, input logic empty,
                             input logic url);
        while (jitter_on && $urandom_range(0, 99) < 19)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        data_byte   <= b;
        last_byte   <= last;
        is_empty    <= empty;
        url_is_text <= url;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        words_sent++;
        track_word(b, last, empty, url);
    endtask

    // Send the queued bytes as one resource; an empty word ends it when asked for or when there are no bytes
    task automatic send_resource(input logic via_empty, input logic url);
        int n;
        int i;
        n = resource_bytes.size();
        for (i = 0; i < n; i++)
            send_word(resource_bytes[i], (i == n - 1) && !via_empty, 1'b0,
                      (i == n - 1) ? url : 1'($urandom_range(0, 1)));
        if (via_empty || n == 0)
            send_word(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1, url);
        resource_bytes.delete();
    endtask

    task automatic wait_for_drain();
        in_valid <= 1'b0;
        while (expected_types.size() != 0)
            @(posedge clk);
    endtask

    task automatic push_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            resource_bytes.push_back(s[i]);
    endtask

    task automatic push_ws(input int count);
        int idx;
        repeat (count)
        begin
            idx = $urandom_range(0, 5);
            resource_bytes.push_back((idx == 5) ? 8'h20 : 8'h09 + 8'(idx));
        end
    endtask

    function automatic logic [7:0] mix_case(input logic [7:0] c);
        if (c >= 8'h61 && c <= 8'h7A && $urandom_range(0, 1) == 1)
            return c - 8'd32;
        return c;
    endfunction

    task automatic push_tail();
        repeat ($urandom_range(0, 10))
            resource_bytes.push_back(($urandom_range(0, 3) == 0) ?
                                     8'($urandom_range(0, 255)) : 8'($urandom_range(0, 127)));
    endtask

    // Mostly well-formed openings and signatures with random case, some broken or noise
    task automatic send_random_resource();
        int kind;
        int k;
        int len;
        int i;
        kind = $urandom_range(0, 99);
        if (kind < 35)
        begin
            push_ws($urandom_range(0, 3));
            k   = $urandom_range(0, 4);
            len = html_len(k);
            if ($urandom_range(0, 4) == 0)
                len = $urandom_range(1, len);
            for (i = 0; i < len; i++)
                resource_bytes.push_back(mix_case(html_char(k, i)));
        end
        else if (kind < 65)
        begin
            if ($urandom_range(0, 9) == 0)
                push_ws(1);
            k   = $urandom_range(0, 3);
            len = sig_len(k);
            if ($urandom_range(0, 4) == 0)
                len = $urandom_range(1, len);
            for (i = 0; i < len; i++)
                resource_bytes.push_back(mix_case(sig_char(k, i)));
        end
        else if (kind < 80)
        begin
            repeat ($urandom_range(1, 24))
                resource_bytes.push_back(8'($urandom_range(0, 127)));
        end
        else if (kind < 92)
        begin
            repeat ($urandom_range(0, 6))
                resource_bytes.push_back(8'($urandom_range(0, 255)));
        end
        else
            push_ws($urandom_range(1, 4));
        // broken opening or signature: overwrite one byte
        if (kind < 65 && $urandom_range(0, 4) == 0)
            resource_bytes[$urandom_range(0, resource_bytes.size() - 1)] =
                8'($urandom_range(0, 255));
        if (kind < 80)
            push_tail();
        send_resource($urandom_range(0, 9) == 0, 1'($urandom_range(0, 1)));
    endtask

    task automatic test_empty_resource();
        send_resource(1'b1, 1'b1);
        send_resource(1'b1, 1'b0);
    endtask

    task automatic test_signatures();
        push_text("BM");
        send_resource(1'b0, 1'b1);
        resource_bytes = '{8'hFF, 8'hD8};
        send_resource(1'b0, 1'b0);
        resource_bytes = '{8'h89};
        push_text("PnG");
        send_resource(1'b0, 1'b1);
    endtask

    task automatic test_html_after_space();
        push_text(" \t<HEAD");
        send_resource(1'b0, 1'b1);
        // whitespace only cannot open a tag
        resource_bytes = '{8'h0A, 8'h0D, 8'h0B};
        send_resource(1'b0, 1'b1);
    endtask

    task automatic test_short_split();
        // one byte of "bm", then an empty word ends the resource
        push_text("b");
        send_resource(1'b1, 1'b1);
    endtask

    task automatic test_byte_extremes();
        resource_bytes = '{8'h00};
        send_resource(1'b0, 1'b0);
        resource_bytes = '{8'hFF};
        send_resource(1'b0, 1'b1);
    endtask

    // High byte just inside and just past the ASCII window
    task automatic test_ascii_window();
        int i;
        for (i = 0; i < WINDOW; i++)
            resource_bytes.push_back((i == WINDOW - 1) ? 8'h80 : 8'($urandom_range(32, 126)));
        send_resource(1'b0, 1'b1);
        for (i = 0; i < WINDOW + 6; i++)
            resource_bytes.push_back((i == WINDOW) ? 8'hC3 : 8'($urandom_range(32, 126)));
        send_resource(1'b0, 1'b1);
    endtask

    task automatic test_random_traffic();
        int start;
        start = words_sent;
        while (words_sent - start < RANDOM_WORDS)
            send_random_resource();
    endtask

    task automatic test_back_to_back();
        int start;
        start = words_sent;
        jitter_on = 1'b0;
        while (words_sent - start < BURST_WORDS)
            send_random_resource();
        jitter_on = 1'b1;
    endtask

    // Result side: random stall, compare each accepted result word
    always @(posedge clk)
    begin
        sniff_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_types.size() == 0)
            begin
                $error("unexpected result word: type_code %0d use_url_type %0d",
                       type_code, use_url_type);
                mismatch_count++;
            end
            else
            begin
                want = expected_types.pop_front();
                if (type_code !== want.code)
                begin
                    $error("type_code: expected %0d, actual %0d", want.code, type_code);
                    mismatch_count++;
                end
                if (use_url_type !== want.use_url)
                begin
                    $error("use_url_type: expected %0d, actual %0d", want.use_url, use_url_type);
                    mismatch_count++;
                end
            end
        end
        out_stall <= rst_n && jitter_on && ($urandom_range(0, 99) < 19);
    end

    initial
    begin
        clear_sniff_state();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_resource();
        test_signatures();
        test_html_after_space();
        test_short_split();
        test_byte_extremes();
        wait_for_drain();
        test_ascii_window();
        wait_for_drain();
        test_random_traffic();
        wait_for_drain();
        test_back_to_back();

        wait_for_drain();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0 && expected_types.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Watchdog
    initial
    begin
        #5000000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
